// ===== src/range_residual_jacobian_macros.svh =====
// Assertion macros shared by the range residual Jacobian RTL.
`ifndef RANGE_RESIDUAL_JACOBIAN_MACROS_SVH
`define RANGE_RESIDUAL_JACOBIAN_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define RRJ_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("rrj assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define RRJ_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("rrj assertion failed");
`else
`define RRJ_ASSERT_IMP(lbl, ck, rstn, ante, cons)
`define RRJ_ASSERT_NXT(lbl, ck, rstn, ante, cons)
`endif
`endif

// ===== src/rrj_pkg.sv =====
// Types, constants and rounding helpers for the range residual Jacobian block.
`timescale 1ns / 1ps
package rrj_pkg;
	localparam int COORD_W = 24;
	localparam int ROT_W = 18;
	localparam int DIST_W = 23;
	localparam int OUT_W = 48;
	localparam int CFG_W = 54;
	localparam int CFG_IDX_W = 3;
	localparam int V_W = 28;
	localparam int RAD_W = 64;
	localparam int ROOT_W = 31;
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS = 29;
	localparam int NUM_W = 61;
	localparam int U_W = 30;
	localparam int W_W = 32;
	localparam int P_W = 32;
	localparam int E_W = 32;

	localparam logic [CFG_W-1:0] ROT0_RST = 54'd65536;
	localparam logic [CFG_W-1:0] ROT1_RST = 54'd17179869184;
	localparam logic [CFG_W-1:0] ROT2_RST = 54'd4503599627370496;

	localparam logic signed [63:0] SAT_MAX = 64'sd140737488355327;
	localparam logic signed [63:0] SAT_MIN = -64'sd140737488355328;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [ROT_W-1:0] rot_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROT0,
		REG_ROT1,
		REG_ROT2,
		REG_TX,
		REG_TY,
		REG_TZ,
		REG_JEN
	} cfg_reg_t;

	// Sideband that rides along the square root pipeline.
	typedef struct packed {
		coord_t [2:0] a;
		logic [2:0][V_W-1:0] v;
		logic [DIST_W-1:0] d;
	} side_t;

	// Sideband that rides along the divider pipeline.
	typedef struct packed {
		coord_t [2:0] a;
		logic signed [E_W-1:0] e;
		logic degen;
		logic [2:0] neg;
	} mid_t;

	// Divide by 2^s, rounding to nearest with ties away from zero.
	function automatic logic signed [63:0] srnd64(input logic signed [63:0] x,
			input int unsigned s);
		logic signed [63:0] half;
		logic signed [63:0] adj;
		half = 64'sd1 <<< (s - 1);
		adj = $signed({63'b0, x[63]});
		return (x + half - adj) >>> s;
	endfunction

	// Clamp to the 48-bit signed output range.
	function automatic logic signed [OUT_W-1:0] sat48(input logic signed [63:0] x);
		logic signed [63:0] c;
		c = x;
		if (x > SAT_MAX) c = SAT_MAX;
		else if (x < SAT_MIN) c = SAT_MIN;
		return c[OUT_W-1:0];
	endfunction
endpackage

// ===== src/rrj_if.sv =====
// Valid/ready channel interfaces for point pair beats and result beats.
`timescale 1ns / 1ps
interface rrj_pts_if;
	import rrj_pkg::*;
	logic valid;
	logic ready;
	logic signed [COORD_W-1:0] point_a_x;
	logic signed [COORD_W-1:0] point_a_y;
	logic signed [COORD_W-1:0] point_a_z;
	logic signed [COORD_W-1:0] point_b_x;
	logic signed [COORD_W-1:0] point_b_y;
	logic signed [COORD_W-1:0] point_b_z;
	logic [DIST_W-1:0] measured_distance;

	modport source (output valid, point_a_x, point_a_y, point_a_z, point_b_x, point_b_y,
		point_b_z, measured_distance, input ready);
	modport sink (input valid, point_a_x, point_a_y, point_a_z, point_b_x, point_b_y,
		point_b_z, measured_distance, output ready);
endinterface

interface rrj_res_if;
	import rrj_pkg::*;
	logic valid;
	logic ready;
	logic [OUT_W-1:0] squared_residual;
	logic signed [OUT_W-1:0] jac_rot_x;
	logic signed [OUT_W-1:0] jac_rot_y;
	logic signed [OUT_W-1:0] jac_rot_z;
	logic signed [OUT_W-1:0] jac_trans_x;
	logic signed [OUT_W-1:0] jac_trans_y;
	logic signed [OUT_W-1:0] jac_trans_z;
	logic degenerate_norm;

	modport source (output valid, squared_residual, jac_rot_x, jac_rot_y, jac_rot_z,
		jac_trans_x, jac_trans_y, jac_trans_z, degenerate_norm, input ready);
	modport sink (input valid, squared_residual, jac_rot_x, jac_rot_y, jac_rot_z,
		jac_trans_x, jac_trans_y, jac_trans_z, degenerate_norm, output ready);
endinterface

// ===== src/rrj_isqrt.sv =====
// Pipelined integer square root, one result bit resolved per stage.
`timescale 1ns / 1ps
module rrj_isqrt (
	input  logic clk,
	input  logic en,
	input  logic [rrj_pkg::RAD_W-1:0] rad,
	output logic [rrj_pkg::ROOT_W-1:0] root
);
	import rrj_pkg::*;

	logic [RAD_W-1:0] rem_s [SQRT_STEPS];
	logic [RAD_W-1:0] res_s [SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam logic [RAD_W-1:0] BITV = 64'd1 << (RAD_W - 2 - 2 * k);
		logic [RAD_W-1:0] rem_in;
		logic [RAD_W-1:0] res_in;
		logic [RAD_W-1:0] trial;

		// Select the previous stage, or the radicand for the first one.
		if (k == 0) begin : g_first
			assign rem_in = rad;
			assign res_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign res_in = res_s[k-1];
		end

		assign trial = res_in + BITV;

		// Try the current bit and keep it when the remainder allows.
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					rem_s[k] <= rem_in - trial;
					res_s[k] <= (res_in >> 1) + BITV;
				end else begin
					rem_s[k] <= rem_in;
					res_s[k] <= res_in >> 1;
				end
			end
		end
	end

	assign root = res_s[SQRT_STEPS-1][ROOT_W-1:0];
endmodule

// ===== src/rrj_udiv.sv =====
// Pipelined restoring divider, three numerators over one shared divisor.
`timescale 1ns / 1ps
module rrj_udiv (
	input  logic clk,
	input  logic en,
	input  logic [2:0][rrj_pkg::NUM_W-1:0] num,
	input  logic [rrj_pkg::ROOT_W-1:0] den,
	output logic [2:0][rrj_pkg::DIV_STEPS-1:0] quo
);
	import rrj_pkg::*;

	logic [2:0][NUM_W-1:0] rem_s [DIV_STEPS];
	logic [2:0][DIV_STEPS-1:0] quo_s [DIV_STEPS];
	logic [ROOT_W-1:0] den_s [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		localparam int SH = DIV_STEPS - 1 - k;
		logic [2:0][NUM_W-1:0] rem_in;
		logic [2:0][DIV_STEPS-1:0] quo_in;
		logic [ROOT_W-1:0] den_in;
		logic [NUM_W-1:0] trial;

		if (k == 0) begin : g_first
			assign rem_in = num;
			assign quo_in = '0;
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign quo_in = quo_s[k-1];
			assign den_in = den_s[k-1];
		end

		assign trial = NUM_W'(den_in) << SH;

		// Each lane subtracts the shifted divisor when it fits.
		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k] <= den_in;
				for (int i = 0; i < 3; i++) begin
					if (rem_in[i] >= trial) begin
						rem_s[k][i] <= rem_in[i] - trial;
						quo_s[k][i] <= quo_in[i] | (DIV_STEPS'(1) << SH);
					end else begin
						rem_s[k][i] <= rem_in[i];
						quo_s[k][i] <= quo_in[i];
					end
				end
			end
		end
	end

	assign quo = quo_s[DIV_STEPS-1];
endmodule

// ===== src/range_residual_jacobian.sv =====
// Top level of the range residual and pose Jacobian pipeline.
// Usage:
//   Point pair beats enter on pts (valid/ready) and one result beat per pair leaves
//   on res. Each pair carries points a and b (Q12.12) and a measured distance.
//   The user must write the pose (three rotation rows, translation, Jacobian
//   enable) through cfg_we/cfg_index/cfg_wdata only while no pair is in flight;
//   the block does not enforce this. Between pts acceptance and res valid, 4 stages
//   form v and |v|^2, 32 stages take the square root, 1 stage forms the error and
//   the divider operands, 29 stages divide v by the norm, and 7 stages build the
//   Jacobian row and the output register.
//   Throughput is one pair per cycle while res is not stalled; the square root and
//   divider pipelines resolve one bit per stage so nothing iterates.
//   Reset clears all valid bits and loads the identity rotation, zero
//   translation and Jacobian enabled.
//   When res is stalled with a valid result the whole pipeline holds and pts.ready
//   drops; no beat is lost or repeated.
`timescale 1ns / 1ps
`include "range_residual_jacobian_macros.svh"
module range_residual_jacobian (
	input  logic clk,
	input  logic arst_n,
	rrj_pts_if.sink pts,
	rrj_res_if.source res,
	input  logic cfg_we,
	input  logic [rrj_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rrj_pkg::CFG_W-1:0] cfg_wdata
);
	import rrj_pkg::*;

	localparam int LAT = 4 + SQRT_STEPS + 1 + DIV_STEPS + 7;
	localparam int NEXT1 [3] = '{1, 2, 0};
	localparam int NEXT2 [3] = '{2, 0, 1};

	// Configuration registers.
	logic [CFG_W-1:0] rot_q [3];
	coord_t trans_q [3];
	logic jen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[0] <= ROT0_RST;
			rot_q[1] <= ROT1_RST;
			rot_q[2] <= ROT2_RST;
			trans_q[0] <= '0;
			trans_q[1] <= '0;
			trans_q[2] <= '0;
			jen_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ROT0: rot_q[0] <= cfg_wdata;
				REG_ROT1: rot_q[1] <= cfg_wdata;
				REG_ROT2: rot_q[2] <= cfg_wdata;
				REG_TX:   trans_q[0] <= cfg_wdata[COORD_W-1:0];
				REG_TY:   trans_q[1] <= cfg_wdata[COORD_W-1:0];
				REG_TZ:   trans_q[2] <= cfg_wdata[COORD_W-1:0];
				REG_JEN:  jen_q <= cfg_wdata[0];
				default:  ;
			endcase
		end
	end

	// Unpack the rotation matrix.
	rot_t rmat [3][3];
	always_comb begin
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				rmat[i][j] = $signed(rot_q[i][ROT_W*j +: ROT_W]);
	end

	// Pipeline control: all stages advance together unless the output is stuck.
	logic [LAT-1:0] vld_q;
	logic en;
	assign en = !vld_q[LAT-1] || res.ready;
	assign pts.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[LAT-2:0], pts.valid};
	end

	// Input beat as arrays.
	coord_t pa [3];
	coord_t pb [3];
	always_comb begin
		pa[0] = pts.point_a_x;
		pa[1] = pts.point_a_y;
		pa[2] = pts.point_a_z;
		pb[0] = pts.point_b_x;
		pb[1] = pts.point_b_y;
		pb[2] = pts.point_b_z;
	end

	// Stage 1: rotation products.
	logic signed [41:0] prod_c [3][3];
	logic signed [41:0] prod_s1 [3][3];
	coord_t a_s1 [3];
	coord_t b_s1 [3];
	logic [DIST_W-1:0] d_s1;
	always_comb begin
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				prod_c[i][j] = rmat[i][j] * pa[j];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod_c;
			a_s1 <= pa;
			b_s1 <= pb;
			d_s1 <= pts.measured_distance;
		end
	end

	// Stage 2: difference vector v = b - R*a - t in Q.12.
	logic signed [63:0] acc_c [3];
	logic signed [63:0] vr_c [3];
	logic signed [V_W-1:0] v_s2 [3];
	coord_t a_s2 [3];
	logic [DIST_W-1:0] d_s2;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc_c[i] = (64'(b_s1[i]) <<< 16) - (64'(trans_q[i]) <<< 16)
				- 64'(prod_s1[i][0]) - 64'(prod_s1[i][1]) - 64'(prod_s1[i][2]);
			vr_c[i] = srnd64(acc_c[i], 16);
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) v_s2[i] <= vr_c[i][V_W-1:0];
			a_s2 <= a_s1;
			d_s2 <= d_s1;
		end
	end

	// Stage 3: squared components.
	logic signed [2*V_W-1:0] vsq_c [3];
	logic signed [2*V_W-1:0] vsq_s3 [3];
	logic signed [V_W-1:0] v_s3 [3];
	coord_t a_s3 [3];
	logic [DIST_W-1:0] d_s3;
	always_comb begin
		for (int i = 0; i < 3; i++) vsq_c[i] = v_s2[i] * v_s2[i];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			vsq_s3 <= vsq_c;
			v_s3 <= v_s2;
			a_s3 <= a_s2;
			d_s3 <= d_s2;
		end
	end

	// Stage 4: radicand |v|^2 * 2^8 and the sideband bundle.
	logic [2*V_W-1:0] ss_c;
	logic [RAD_W-1:0] rad_s4;
	side_t side_s4;
	assign ss_c = vsq_s3[0] + vsq_s3[1] + vsq_s3[2];
	always_ff @(posedge clk) begin
		if (en) begin
			rad_s4 <= {ss_c, 8'b0};
			for (int i = 0; i < 3; i++) begin
				side_s4.a[i] <= a_s3[i];
				side_s4.v[i] <= v_s3[i];
			end
			side_s4.d <= d_s3;
		end
	end

	// Square root pipeline with its sideband delay line.
	logic [ROOT_W-1:0] root;
	side_t side_q [SQRT_STEPS];

	rrj_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.rad  (rad_s4),
		.root (root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_s4;
			for (int k = 1; k < SQRT_STEPS; k++) side_q[k] <= side_q[k-1];
		end
	end

	// Stage 5: error e = n - 16*d and the divider operands.
	side_t side_l;
	logic signed [V_W-1:0] vv_c [3];
	logic [V_W-1:0] mv_c [3];
	logic [2:0][NUM_W-1:0] num_s5;
	logic [ROOT_W-1:0] den_s5;
	mid_t mid_s5;
	assign side_l = side_q[SQRT_STEPS-1];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vv_c[i] = $signed(side_l.v[i]);
			mv_c[i] = vv_c[i][V_W-1] ? V_W'(-vv_c[i]) : V_W'(vv_c[i]);
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				num_s5[i] <= NUM_W'({mv_c[i], 32'b0}) + NUM_W'(root[ROOT_W-1:1]);
				mid_s5.neg[i] <= vv_c[i][V_W-1];
			end
			den_s5 <= root;
			mid_s5.a <= side_l.a;
			mid_s5.e <= $signed({1'b0, root}) - $signed({5'b0, side_l.d, 4'b0});
			mid_s5.degen <= (root == '0);
		end
	end

	// Divider pipeline giving |v_i| / |v| in Q.28.
	logic [2:0][DIV_STEPS-1:0] quo;
	mid_t mid_q [DIV_STEPS];

	rrj_udiv u_udiv (
		.clk (clk),
		.en  (en),
		.num (num_s5),
		.den (den_s5),
		.quo (quo)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			mid_q[0] <= mid_s5;
			for (int k = 1; k < DIV_STEPS; k++) mid_q[k] <= mid_q[k-1];
		end
	end

	// Stage 6: signed unit vector u.
	mid_t mid_l;
	logic signed [U_W-1:0] u_s6 [3];
	coord_t a_s6 [3];
	logic signed [E_W-1:0] e_s6;
	logic degen_s6;
	assign mid_l = mid_q[DIV_STEPS-1];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				u_s6[i] <= mid_l.neg[i] ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
				a_s6[i] <= mid_l.a[i];
			end
			e_s6 <= mid_l.e;
			degen_s6 <= mid_l.degen;
		end
	end

	// Stage 7: products u_i * R_ij.
	logic signed [U_W+ROT_W-1:0] ur_c [3][3];
	logic signed [U_W+ROT_W-1:0] ur_s7 [3][3];
	logic signed [U_W-1:0] u_s7 [3];
	coord_t a_s7 [3];
	logic signed [E_W-1:0] e_s7;
	logic degen_s7;
	always_comb begin
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				ur_c[i][j] = u_s6[i] * rmat[i][j];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ur_s7 <= ur_c;
			u_s7 <= u_s6;
			a_s7 <= a_s6;
			e_s7 <= e_s6;
			degen_s7 <= degen_s6;
		end
	end

	// Stage 8: w = R^T * u in Q.28.
	logic signed [63:0] wr_c [3];
	logic signed [W_W-1:0] w_s8 [3];
	logic signed [U_W-1:0] u_s8 [3];
	coord_t a_s8 [3];
	logic signed [E_W-1:0] e_s8;
	logic degen_s8;
	always_comb begin
		for (int j = 0; j < 3; j++)
			wr_c[j] = srnd64(64'(ur_s7[0][j]) + 64'(ur_s7[1][j]) + 64'(ur_s7[2][j]), 16);
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) w_s8[j] <= wr_c[j][W_W-1:0];
			u_s8 <= u_s7;
			a_s8 <= a_s7;
			e_s8 <= e_s7;
			degen_s8 <= degen_s7;
		end
	end

	// Stage 9: cross product terms of w against a.
	logic signed [W_W+COORD_W-1:0] pa_c [3];
	logic signed [W_W+COORD_W-1:0] pb_c [3];
	logic signed [W_W+COORD_W-1:0] pa_s9 [3];
	logic signed [W_W+COORD_W-1:0] pb_s9 [3];
	logic signed [U_W-1:0] u_s9 [3];
	logic signed [E_W-1:0] e_s9;
	logic degen_s9;
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pa_c[k] = w_s8[NEXT1[k]] * a_s8[NEXT2[k]];
			pb_c[k] = w_s8[NEXT2[k]] * a_s8[NEXT1[k]];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			pa_s9 <= pa_c;
			pb_s9 <= pb_c;
			u_s9 <= u_s8;
			e_s9 <= e_s8;
			degen_s9 <= degen_s8;
		end
	end

	// Stage 10: p = w^T * skew(a) in Q.16.
	logic signed [63:0] pr_c [3];
	logic signed [P_W-1:0] p_s10 [3];
	logic signed [U_W-1:0] u_s10 [3];
	logic signed [E_W-1:0] e_s10;
	logic degen_s10;
	always_comb begin
		for (int k = 0; k < 3; k++)
			pr_c[k] = srnd64(64'(pa_s9[k]) - 64'(pb_s9[k]), 24);
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) p_s10[k] <= pr_c[k][P_W-1:0];
			u_s10 <= u_s9;
			e_s10 <= e_s9;
			degen_s10 <= degen_s9;
		end
	end

	// Stage 11: products with the error term.
	logic signed [63:0] ep_c [3];
	logic signed [63:0] eu_c [3];
	logic signed [63:0] ee_c;
	logic signed [63:0] ep_s11 [3];
	logic signed [63:0] eu_s11 [3];
	logic signed [63:0] ee_s11;
	logic degen_s11;
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ep_c[k] = e_s10 * p_s10[k];
			eu_c[k] = e_s10 * u_s10[k];
		end
		ee_c = e_s10 * e_s10;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ep_s11 <= ep_c;
			eu_s11 <= eu_c;
			ee_s11 <= ee_c;
			degen_s11 <= degen_s10;
		end
	end

	// Stage 12: rounding, saturation and the output register.
	logic [63:0] sqr_c;
	logic [OUT_W-1:0] sq_sat_c;
	logic signed [OUT_W-1:0] jr_c [3];
	logic signed [63:0] jt_full_c [3];
	logic jac_ok_c;
	logic [OUT_W-1:0] sq_s12;
	logic signed [OUT_W-1:0] jr_s12 [3];
	logic signed [OUT_W-1:0] jt_s12 [3];
	logic degen_s12;
	always_comb begin
		sqr_c = ($unsigned(ee_s11) + 64'd128) >> 8;
		sq_sat_c = (|sqr_c[63:OUT_W]) ? '1 : sqr_c[OUT_W-1:0];
		jac_ok_c = jen_q && !degen_s11;
		for (int k = 0; k < 3; k++) begin
			jr_c[k] = sat48(srnd64(ep_s11[k], 7));
			jt_full_c[k] = -srnd64(eu_s11[k], 19);
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s12 <= sq_sat_c;
			degen_s12 <= degen_s11;
			for (int k = 0; k < 3; k++) begin
				jr_s12[k] <= jac_ok_c ? jr_c[k] : '0;
				jt_s12[k] <= jac_ok_c ? jt_full_c[k][OUT_W-1:0] : '0;
			end
		end
	end

	assign res.valid = vld_q[LAT-1];
	assign res.squared_residual = sq_s12;
	assign res.jac_rot_x = jr_s12[0];
	assign res.jac_rot_y = jr_s12[1];
	assign res.jac_rot_z = jr_s12[2];
	assign res.jac_trans_x = jt_s12[0];
	assign res.jac_trans_y = jt_s12[1];
	assign res.jac_trans_z = jt_s12[2];
	assign res.degenerate_norm = degen_s12;

	// A zero norm always comes out with an all-zero Jacobian row.
	`RRJ_ASSERT_IMP(a_degen_zero, clk, arst_n, res.valid && res.degenerate_norm, jr_s12[0] == 0 && jr_s12[1] == 0 && jr_s12[2] == 0 && jt_s12[0] == 0 && jt_s12[1] == 0 && jt_s12[2] == 0)
	// An accepted beat occupies the first stage on the next cycle.
	`RRJ_ASSERT_NXT(a_accept_enters, clk, arst_n, pts.valid && pts.ready, vld_q[0])
	// A stall freezes every valid bit of the pipeline.
	`RRJ_ASSERT_NXT(a_stall_hold, clk, arst_n, !en, $stable(vld_q))
endmodule
